FILE: rtl/lpd_pkg.sv
`default_nettype none

package lpd_pkg;

    localparam int NUM_ANGLES  = 360;
    localparam int FRAME_BYTES = 22;
    localparam int MAP_ROWS    = NUM_ANGLES / 4;
    localparam int POS_W       = 5;
    localparam int ROW_W       = 7;
    localparam int ACC_W       = 26;

    localparam logic [7:0] START_BYTE = 8'hFA;
    localparam logic [7:0] IDX_LOW    = 8'hA0;
    localparam logic [7:0] IDX_HIGH   = 8'hF9;

    localparam logic [POS_W-1:0] LAST_POS      = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] LAST_WORD_POS = POS_W'(FRAME_BYTES - 3);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [9:0]       speed;
        logic [3:0][7:0]  lo;
        logic [3:0][7:0]  hi;
        logic             ok;
    } t_frame;

endpackage

`default_nettype wire

FILE: rtl/lpd_collect.sv
`default_nettype none

module lpd_collect
    import lpd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_at_last,
    output logic            o_done,
    output t_frame          o_frame
);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_fb [1:19];
    logic [7:0]       r_lo;
    logic [ACC_W-1:0] r_acc;
    logic [15:0]      w_sum;
    logic             w_idx_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            if (r_pos == '0) begin
                r_pos <= (i_rx_byte == START_BYTE) ? POS_W'(1) : '0;
            end else if (r_pos == LAST_POS) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (r_pos == '0) begin
                r_lo  <= START_BYTE;
                r_acc <= '0;
            end else begin
                if (r_pos <= LAST_WORD_POS) begin
                    r_fb[r_pos] <= i_rx_byte;
                end
                if (!r_pos[0]) begin
                    r_lo <= i_rx_byte;
                end else if (r_pos <= LAST_WORD_POS) begin
                    r_acc <= {r_acc[ACC_W-2:0], 1'b0}
                           + {{(ACC_W-16){1'b0}}, i_rx_byte, r_lo};
                end
            end
        end
    end

    // The checksum folds the accumulator to 15 bits once, after the last word.
    assign w_sum    = {1'b0, r_acc[14:0]} + {5'b0, r_acc[ACC_W-1:15]};
    assign w_idx_ok = (r_fb[1] >= IDX_LOW) && (r_fb[1] <= IDX_HIGH);

    always_comb begin
        o_frame.row   = ROW_W'(r_fb[1] - IDX_LOW);
        o_frame.speed = {r_fb[3], r_fb[2][7:6]};
        for (int i = 0; i < 4; i++) begin
            o_frame.lo[i] = r_fb[4 + 4*i];
            o_frame.hi[i] = r_fb[5 + 4*i];
        end
        o_frame.ok = ({1'b0, w_sum[14:0]} == {i_rx_byte, r_lo});
    end

    assign o_at_last = (r_pos == LAST_POS);
    assign o_done    = i_accept && o_at_last && w_idx_ok;

endmodule

`default_nettype wire

FILE: rtl/lidar_packet_deframer.sv
// A frame passes the decode buffer, the update and emit states and the output register.
// Throughput: one input word per cycle but for a stalled last word; a frame gives four
// readings, one per cycle while the output is not stalled. The last word of a frame is
// stalled while the previous frame is updated or its readings issued, set by the single
// frame decode buffer. Reset is synchronous, active low: hunting for a start word,
// counters at zero, and the angle map cleared through its per-row valid bits.
`default_nettype none

module lidar_packet_deframer
    import lpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [8:0]       o_angle,
    output logic [13:0]      o_range_value,
    output logic             o_inv_bit,
    output logic             o_warn_bit,
    output logic             o_checksum_ok,
    output logic [9:0]       o_rotation_speed,
    output logic [15:0]      o_good_count,
    output logic [15:0]      o_bad_count,
    output logic [8:0]       o_covered_count,
    output logic             o_full_scan,
    output logic             o_last
);

    typedef enum logic [1:0] {ST_IDLE, ST_UPDATE, ST_EMIT} t_state;

    t_state        r_state;
    t_frame        r_frm;
    t_frame        w_frame;
    logic          w_at_last;
    logic          w_done;
    logic          w_accept;
    logic          w_load;
    logic [1:0]    r_rd;
    logic [8:0]    r_total;
    logic [8:0]    n_total;
    logic [15:0]   r_good;
    logic [15:0]   r_bad;
    logic [15:0]   n_good;
    logic [15:0]   n_bad;
    logic [8:0]    r_snap;

    logic [3:0]          r_map [MAP_ROWS];
    logic [MAP_ROWS-1:0] r_row_vld;
    logic [3:0]          r_map_q;
    logic                r_vld_q;
    logic [3:0]          w_old_row;
    logic [3:0]          w_new_row;
    logic [2:0]          w_pop_old;
    logic [2:0]          w_pop_new;

    logic [7:0]    w_lo;
    logic [7:0]    w_hi;
    logic [13:0]   w_dist;
    logic          w_good;

    logic          r_o_vld;
    logic [8:0]    r_o_angle;
    logic [13:0]   r_o_range;
    logic          r_o_inv;
    logic          r_o_warn;
    logic          r_o_ok;
    logic [9:0]    r_o_speed;
    logic [15:0]   r_o_good;
    logic [15:0]   r_o_bad;
    logic [8:0]    r_o_cov;
    logic          r_o_full;
    logic          r_o_last;

    lpd_collect u_collect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_at_last (w_at_last),
        .o_done    (w_done),
        .o_frame   (w_frame)
    );

    assign o_in_stall = w_at_last && (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load     = !r_o_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE && r_frm.ok) begin
            r_map[r_frm.row] <= w_new_row;
        end
        if (w_done) begin
            r_map_q <= r_map[w_frame.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (r_state == ST_UPDATE && r_frm.ok) begin
            r_row_vld[r_frm.row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_vld_q <= r_row_vld[w_frame.row];
        end
    end

    always_comb begin
        w_old_row = r_vld_q ? r_map_q : 4'b0;
        for (int i = 0; i < 4; i++) begin
            w_new_row[i] = !r_frm.hi[i][7] && ({r_frm.hi[i][5:0], r_frm.lo[i]} != 14'd0);
        end
        w_pop_old = {2'b0, w_old_row[0]} + {2'b0, w_old_row[1]}
                  + {2'b0, w_old_row[2]} + {2'b0, w_old_row[3]};
        w_pop_new = {2'b0, w_new_row[0]} + {2'b0, w_new_row[1]}
                  + {2'b0, w_new_row[2]} + {2'b0, w_new_row[3]};
        n_total   = r_total + {6'b0, w_pop_new} - {6'b0, w_pop_old};
    end

    always_comb begin
        w_lo   = r_frm.lo[r_rd];
        w_hi   = r_frm.hi[r_rd];
        w_dist = {w_hi[5:0], w_lo};
        w_good = r_frm.ok && !w_hi[7];
        n_good = w_good ? r_good + 16'd1 : r_good;
        n_bad  = w_good ? r_bad : r_bad + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd    <= '0;
            r_total <= '0;
            r_good  <= '0;
            r_bad   <= '0;
            r_snap  <= '0;
            r_o_vld <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_done) begin
                        r_frm   <= w_frame;
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (r_frm.ok) begin
                        r_total <= n_total;
                    end
                    if (r_frm.row == '0) begin
                        r_snap <= r_total;
                        r_good <= '0;
                        r_bad  <= '0;
                    end
                    r_rd    <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_good <= n_good;
                        r_bad  <= n_bad;
                        r_rd   <= r_rd + 2'd1;
                        if (r_rd == 2'd3) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_load) begin
                r_o_vld   <= (r_state == ST_EMIT);
                r_o_angle <= {r_frm.row, r_rd};
                r_o_range <= w_good ? w_dist : 14'd0;
                r_o_inv   <= w_hi[7];
                r_o_warn  <= w_hi[6];
                r_o_ok    <= r_frm.ok;
                r_o_speed <= r_frm.speed;
                r_o_good  <= n_good;
                r_o_bad   <= n_bad;
                r_o_cov   <= r_snap;
                r_o_full  <= (r_snap == 9'(NUM_ANGLES));
                r_o_last  <= (r_rd == 2'd3);
            end
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_angle          = r_o_angle;
    assign o_range_value    = r_o_range;
    assign o_inv_bit        = r_o_inv;
    assign o_warn_bit       = r_o_warn;
    assign o_checksum_ok    = r_o_ok;
    assign o_rotation_speed = r_o_speed;
    assign o_good_count     = r_o_good;
    assign o_bad_count      = r_o_bad;
    assign o_covered_count  = r_o_cov;
    assign o_full_scan      = r_o_full;
    assign o_last           = r_o_last;

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= 9'(NUM_ANGLES))
        else $error("nonzero angle total exceeds the number of angles");

    a_update_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPDATE |=> r_state == ST_EMIT)
        else $error("map update not followed by reading issue");

    a_last_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_angle[1:0] == 2'b11)
        else $error("last reading of a frame at wrong angle offset");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_state != ST_IDLE)
        else $error("input stalled with an empty decode buffer");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_WORDS   = 240;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RESET_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [8:0]  angle;
        logic [13:0] range_value;
        logic        inv_bit;
        logic        warn_bit;
        logic        checksum_ok;
        logic [9:0]  rotation_speed;
        logic [15:0] good_count;
        logic [15:0] bad_count;
        logic [8:0]  covered_count;
        logic        full_scan;
        logic        last;
    } t_reading;

    typedef logic [7:0] t_frame_bytes [FRAME_BYTES];

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [8:0]  o_angle;
    logic [13:0] o_range_value;
    logic        o_inv_bit;
    logic        o_warn_bit;
    logic        o_checksum_ok;
    logic [9:0]  o_rotation_speed;
    logic [15:0] o_good_count;
    logic [15:0] o_bad_count;
    logic [8:0]  o_covered_count;
    logic        o_full_scan;
    logic        o_last;

    logic [7:0] rx_stream [$];
    t_reading   readings_due [$];

    int words_sent   = 0;
    int total_words  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Shadow copy of the deframer state.
    int           frame_pos;
    t_frame_bytes frame_buf;
    bit           angle_hit [NUM_ANGLES];
    logic [8:0]   hit_total;
    logic [15:0]  good_run;
    logic [15:0]  bad_run;
    logic [8:0]   covered_snap;

    lidar_packet_deframer i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (in_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_angle          (o_angle),
        .o_range_value    (o_range_value),
        .o_inv_bit        (o_inv_bit),
        .o_warn_bit       (o_warn_bit),
        .o_checksum_ok    (o_checksum_ok),
        .o_rotation_speed (o_rotation_speed),
        .o_good_count     (o_good_count),
        .o_bad_count      (o_bad_count),
        .o_covered_count  (o_covered_count),
        .o_full_scan      (o_full_scan),
        .o_last           (o_last)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [14:0] fold_checksum(t_frame_bytes fr);
        logic [31:0] acc;
        acc = '0;
        for (int k = 0; k < 10; k++) begin
            acc = (acc << 1) + 32'({fr[2*k+1], fr[2*k]});
        end
        return 15'(((acc & 32'h7FFF) + (acc >> 15)) & 32'h7FFF);
    endfunction

    task automatic set_angle(int a, bit nz);
        if (nz && !angle_hit[a]) begin
            angle_hit[a] = 1'b1;
            hit_total++;
        end else if (!nz && angle_hit[a]) begin
            angle_hit[a] = 1'b0;
            hit_total--;
        end
    endtask

    task automatic decode_frame_bytes();
        logic [7:0]  idx;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [13:0] span;
        logic [9:0]  speed;
        logic        ok;
        int          base;
        t_reading    r;
        idx = frame_buf[1];
        if (idx < IDX_LOW || idx > IDX_HIGH) return;
        base  = 4 * int'(idx - IDX_LOW);
        ok    = {1'b0, fold_checksum(frame_buf)} == {frame_buf[21], frame_buf[20]};
        speed = 10'({frame_buf[3], frame_buf[2]} >> 6);
        if (base == 0) begin
            covered_snap = hit_total;
            good_run     = '0;
            bad_run      = '0;
        end
        for (int k = 0; k < 4; k++) begin
            lo   = frame_buf[4 + 4*k];
            hi   = frame_buf[5 + 4*k];
            span = {hi[5:0], lo};
            r.range_value = '0;
            if (!ok) begin
                bad_run++;
            end else if (!hi[7]) begin
                set_angle(base + k, span != 0);
                good_run++;
                r.range_value = span;
            end else begin
                set_angle(base + k, 1'b0);
                bad_run++;
            end
            r.angle          = 9'(base + k);
            r.inv_bit        = hi[7];
            r.warn_bit       = hi[6];
            r.checksum_ok    = ok;
            r.rotation_speed = speed;
            r.good_count     = good_run;
            r.bad_count      = bad_run;
            r.covered_count  = covered_snap;
            r.full_scan      = covered_snap == NUM_ANGLES;
            r.last           = k == 3;
            readings_due.push_back(r);
        end
    endtask

    task automatic take_rx_byte(logic [7:0] b);
        if (frame_pos == 0) begin
            frame_pos = (b == START_BYTE) ? 1 : 0;
        end else begin
            frame_buf[frame_pos] = b;
            frame_pos++;
            if (frame_pos == FRAME_BYTES) begin
                frame_pos = 0;
                decode_frame_bytes();
            end
        end
    endtask

    function automatic t_frame_bytes random_frame(logic [7:0] idx, bit clean);
        t_frame_bytes fr;
        foreach (fr[k]) fr[k] = 8'($urandom);
        fr[0] = START_BYTE;
        fr[1] = idx;
        for (int k = 0; k < 4; k++) begin
            if (clean) begin
                fr[5 + 4*k][7] = 1'b0;
                if ({fr[5 + 4*k][5:0], fr[4 + 4*k]} == 14'd0) fr[4 + 4*k] = 8'h01;
            end else if ($urandom_range(0, 7) == 0) begin
                fr[4 + 4*k]      = 8'h00;
                fr[5 + 4*k][5:0] = 6'd0;
            end
        end
        return fr;
    endfunction

    task automatic push_frame(t_frame_bytes fr, logic [15:0] spoil);
        logic [15:0] sum;
        sum   = {1'b0, fold_checksum(fr)} ^ spoil;
        fr[20] = sum[7:0];
        fr[21] = sum[15:8];
        foreach (fr[k]) rx_stream.push_back(fr[k]);
    endtask

    function automatic logic [15:0] random_spoil();
        return 16'($urandom_range(1, 16'hFFFF));
    endfunction

    function automatic int idle_pct(bit receiver);
        int phase;
        phase = (words_sent * 3 < total_words) ? 0 :
                (words_sent * 3 < 2 * total_words) ? 1 : 2;
        case (phase)
            0: return receiver ? 85 : 19;
            1: return receiver ? 19 : 85;
            default: return 0;
        endcase
    endfunction

    function automatic string show_reading(t_reading r);
        return $sformatf({"angle=%0d range=%0d inv=%b warn=%b ok=%b speed=%0d",
                          " good=%0d bad=%0d covered=%0d full=%b last=%b"},
                         r.angle, r.range_value, r.inv_bit, r.warn_bit,
                         r.checksum_ok, r.rotation_speed, r.good_count,
                         r.bad_count, r.covered_count, r.full_scan, r.last);
    endfunction

    always @(posedge clk) begin
        bit taken;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && !o_in_stall;
            if (taken) begin
                take_rx_byte(in_byte);
                words_sent++;
            end
            if (!in_valid || taken) begin
                if (rx_stream.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    in_valid <= 1'b1;
                    in_byte  <= rx_stream.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_reading got;
        t_reading want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got = {o_angle, o_range_value, o_inv_bit, o_warn_bit,
                       o_checksum_ok, o_rotation_speed, o_good_count, o_bad_count,
                       o_covered_count, o_full_scan, o_last};
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected reading: %s", show_reading(got));
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("reading mismatch, expected: %s", show_reading(want));
                            $display("                  actual:   %s", show_reading(got));
                        end
                    end
                end
            end
            // The long hold-off lets the deframer fill up and stall its input.
            if (hold_left != 0) begin
                hold_left--;
            end else if (!hold_done && words_sent * 3 >= 2 * total_words + 60) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        t_frame_bytes fr;
        int           target;
        int           pick;
        int           count;
        logic [7:0]   idx;

        frame_pos    = 0;
        frame_buf[0] = START_BYTE;
        foreach (angle_hit[a]) angle_hit[a] = 1'b0;
        hit_total    = '0;
        good_run     = '0;
        bad_run      = '0;
        covered_snap = '0;

        // Noise while hunting.
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(IDX_HIGH);

        // Lap start: full distance, zero distance, invalid with warning, warning alone.
        fr = random_frame(IDX_LOW, 1'b0);
        fr[2]  = 8'hFF;
        fr[3]  = 8'hFF;
        fr[4]  = 8'hFF;
        fr[5]  = 8'h3F;
        fr[8]  = 8'h00;
        fr[9]  = 8'h00;
        fr[12] = 8'hFF;
        fr[13] = 8'hFF;
        fr[16] = 8'h55;
        fr[17] = 8'h7F;
        push_frame(fr, 16'h0000);

        fr = random_frame(IDX_HIGH, 1'b1);
        fr[2] = 8'h00;
        fr[3] = 8'h00;
        push_frame(fr, 16'h0000);

        push_frame(random_frame(8'hA1, 1'b0), random_spoil());
        push_frame(random_frame(IDX_LOW - 8'd1, 1'b1), 16'h0000);
        push_frame(random_frame(IDX_HIGH + 8'd1, 1'b1), 16'h0000);

        // A start byte inside the payload, then a frame right behind it.
        fr = random_frame(8'hA2, 1'b1);
        fr[6] = START_BYTE;
        push_frame(fr, 16'h0000);
        push_frame(random_frame(IDX_LOW, 1'b1), random_spoil());
        push_frame(random_frame(8'hA3, 1'b1), 16'h8000);

        // A frame cut short swallows the start of the next one.
        rx_stream.push_back(START_BYTE);
        for (int k = 0; k < 10; k++) rx_stream.push_back(8'($urandom));
        push_frame(random_frame(8'hA4, 1'b1), 16'h0000);

        // A second lap start that snapshots the angles seen so far.
        push_frame(random_frame(IDX_LOW, 1'b1), 16'h0000);

        target = rx_stream.size() + RANDOM_WORDS;
        while (rx_stream.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                idx = (pick < 8) ? IDX_LOW : 8'($urandom_range(IDX_LOW, IDX_HIGH));
                push_frame(random_frame(idx, 1'($urandom_range(0, 1))), 16'h0000);
            end else if (pick < 67) begin
                idx = 8'($urandom_range(IDX_LOW, IDX_HIGH));
                push_frame(random_frame(idx, 1'b0), random_spoil());
            end else if (pick < 77) begin
                idx = $urandom_range(0, 1) ? 8'($urandom_range(0, IDX_LOW - 1))
                                           : 8'($urandom_range(IDX_HIGH + 1, 255));
                push_frame(random_frame(idx, 1'b0), 16'h0000);
            end else if (pick < 87) begin
                count = $urandom_range(1, 4);
                for (int k = 0; k < count; k++) rx_stream.push_back(8'($urandom));
            end else begin
                count = $urandom_range(1, FRAME_BYTES - 2);
                rx_stream.push_back(START_BYTE);
                for (int k = 0; k < count; k++) rx_stream.push_back(8'($urandom));
            end
        end
        total_words = rx_stream.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_stream.size() != 0 || in_valid || readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (readings_due.size() != 0) begin
            $display("%0d expected readings never arrived", readings_due.size());
            mismatches += readings_due.size();
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
